// ===== rtl/core/sct_pkg.sv =====
// Shared types, constants and the divide step for the sine/cosine unit.
// No dependencies; every other file refers to it by scoped names.
package sct_pkg;

  localparam int FRAC       = 59;
  localparam int DW         = 11;
  localparam int DIV_STAGES = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] TWO_PI_Q56        = 64'h06487ED5110B4612;
  localparam logic [63:0] TWO_PI_Q59        = 64'h3243F6A8885A3090;
  localparam logic [63:0] PI_Q59            = 64'h1921FB54442D1847;
  localparam logic [63:0] HALF_PI_Q59       = 64'h0C90FDAA22168C23;
  localparam logic [63:0] THREE_HALF_PI_Q59 = 64'h25B2F8FE6643A46A;
  localparam logic [63:0] ONE_Q59           = 64'h0800000000000000;
  localparam logic [13:0] RECIP_TWO_PI      = 14'd10430;

  typedef struct packed {
    logic        kind;
    logic        neg;
    logic [60:0] x;
  } fold_t;

  typedef struct packed {
    logic               kind;
    logic               neg;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
  } work_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [3:0]    digit;
  } dstep_t;

  // one radix-16 long division digit against a small constant divisor
  function automatic dstep_t div_step(input logic [DW-1:0] rem, input logic [3:0] nib,
                                     input logic [DW-1:0] d);
    logic [DW+3:0] r;
    logic [3:0]    dg;
    dstep_t        s;
    r  = {rem, nib};
    dg = '0;
    for (int k = 1; k < 16; k++) begin
      if (r >= (15'(d) * 15'(k))) dg = 4'(k);
    end
    s.digit = dg;
    s.rem   = DW'(r - (15'(d) * 15'(dg)));
    return s;
  endfunction

endpackage

// ===== rtl/core/sct_front.sv =====
// Front end: accepts angles, reduces them modulo two pi and folds to the first quadrant.
// Depends on sct_pkg.
module sct_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic                kind,
  input  logic signed [31:0]  angle,
  input  logic                full,
  output logic                push,
  output sct_pkg::fold_t      fout
);

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic k1, k2, k3, k4, k5, k6;
  logic g1, g2, g3, g4, g5;
  logic [31:0] m1, m2, m3;
  logic [5:0]  q2;
  logic [63:0] p3, r4, r5, x6;
  logic [45:0] qprod;
  sct_pkg::fold_t fold_next, f7;

  assign en    = ~(v7 & full);
  assign stall = ~en;
  assign push  = v7 & ~full;
  assign fout  = f7;
  assign qprod = 46'(m1) * 46'(sct_pkg::RECIP_TWO_PI);

  always_comb begin
    fold_next.kind = k6;
    fold_next.neg  = 1'b0;
    fold_next.x    = x6[60:0];
    if (x6 > sct_pkg::THREE_HALF_PI_Q59) begin
      fold_next.neg = ~k6;
      fold_next.x   = 61'(sct_pkg::TWO_PI_Q59 - x6);
    end else if (x6 > sct_pkg::PI_Q59) begin
      fold_next.neg = 1'b1;
      fold_next.x   = 61'(x6 - sct_pkg::PI_Q59);
    end else if (x6 > sct_pkg::HALF_PI_Q59) begin
      fold_next.neg = k6;
      fold_next.x   = 61'(sct_pkg::PI_Q59 - x6);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7} <= {valid, v1, v2, v3, v4, v5, v6};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= kind;
      g1 <= angle[31];
      m1 <= angle[31] ? 32'(-angle) : 32'(angle);
      k2 <= k1; g2 <= g1; m2 <= m1; q2 <= qprod[45:40];
      k3 <= k2; g3 <= g2; m3 <= m2; p3 <= 64'(q2) * sct_pkg::TWO_PI_Q56;
      k4 <= k3; g4 <= g3; r4 <= {m3, 32'b0} - p3;
      k5 <= k4; g5 <= g4;
      r5 <= (r4 >= sct_pkg::TWO_PI_Q56) ? r4 - sct_pkg::TWO_PI_Q56 : r4;
      k6 <= k5;
      x6 <= ((g5 && r5 != 64'd0) ? sct_pkg::TWO_PI_Q56 - r5 : r5) << 3;
      f7 <= fold_next;
    end
  end

endmodule

// ===== rtl/core/sct_queue.sv =====
// Short queue between front and back end.
// Depends on sct_pkg.
module sct_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sct_pkg::fold_t wdata,
  input  logic           pop,
  output sct_pkg::fold_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int AW = $clog2(sct_pkg::QUEUE_DEPTH);

  sct_pkg::fold_t mem [sct_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(sct_pkg::QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

// ===== rtl/core/sct_mul.sv =====
// Three-stage Q59 multiplier built from 32x32 partial products; carries a work item along.
// Depends on sct_pkg.
module sct_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  sct_pkg::work_t win,
  input  logic [63:0]    a,
  input  logic [63:0]    b,
  output logic           vout,
  output sct_pkg::work_t wout,
  output logic [63:0]    prod
);

  logic v1, v2;
  sct_pkg::work_t w1, w2;
  logic [63:0]  p00, p01, p10, p11, q00, q11;
  logic [64:0]  mid;
  logic [127:0] full;

  assign full = {q11, q00} + {31'b0, mid, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; vout <= 1'b0;
    end else if (en) begin
      v1 <= vin; v2 <= v1; vout <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1  <= win;
      p00 <= a[31:0]  * b[31:0];
      p01 <= a[31:0]  * b[63:32];
      p10 <= a[63:32] * b[31:0];
      p11 <= a[63:32] * b[63:32];
      w2  <= w1;
      q00 <= p00;
      q11 <= p11;
      mid <= {1'b0, p01} + {1'b0, p10};
      wout <= w2;
      prod <= full[122:59];
    end
  end

endmodule

// ===== rtl/core/sct_term.sv =====
// One series term: multiply by x squared, divide by the term's factorial step, accumulate.
// Depends on sct_pkg and sct_mul.
module sct_term #(
  parameter int TERM_IDX = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  sct_pkg::work_t win,
  output logic           vout,
  output sct_pkg::work_t wout
);

  localparam int NS = sct_pkg::DIV_STAGES;
  localparam logic [sct_pkg::DW-1:0] D_SIN =
    sct_pkg::DW'((2*TERM_IDX) * (2*TERM_IDX + 1));
  localparam logic [sct_pkg::DW-1:0] D_COS =
    sct_pkg::DW'((2*TERM_IDX - 1) * (2*TERM_IDX));

  logic           mv;
  sct_pkg::work_t mw;
  logic [63:0]    mprod;

  logic                   dv   [NS];
  sct_pkg::work_t         dw   [NS];
  logic [sct_pkg::DW-1:0] drem [NS];
  logic [63:0]            dnum [NS];
  logic [63:0]            dquo [NS];

  logic                   cv   [NS];
  sct_pkg::work_t         cw   [NS];
  logic [sct_pkg::DW-1:0] crem [NS];
  logic [63:0]            cnum [NS];
  logic [63:0]            cquo [NS];
  logic [sct_pkg::DW-1:0] cd   [NS];
  sct_pkg::dstep_t        s0   [NS];
  sct_pkg::dstep_t        s1   [NS];

  sct_pkg::work_t         wout_next;

  sct_mul u_mul (
    .clk (clk), .rst (rst), .en (en), .vin (vin), .win (win),
    .a (win.term), .b (win.x2),
    .vout (mv), .wout (mw), .prod (mprod)
  );

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        cv[i] = mv; cw[i] = mw; crem[i] = '0; cnum[i] = mprod; cquo[i] = '0;
      end else begin
        cv[i] = dv[i-1]; cw[i] = dw[i-1]; crem[i] = drem[i-1];
        cnum[i] = dnum[i-1]; cquo[i] = dquo[i-1];
      end
      cd[i] = cw[i].kind ? D_COS : D_SIN;
      s0[i] = sct_pkg::div_step(crem[i], cnum[i][63:60], cd[i]);
      s1[i] = sct_pkg::div_step(s0[i].rem, cnum[i][59:56], cd[i]);
    end
  end

  always_comb begin
    wout_next      = dw[NS-1];
    wout_next.term = dquo[NS-1];
    wout_next.sum  = (TERM_IDX % 2 == 1) ? dw[NS-1].sum - signed'(dquo[NS-1])
                                         : dw[NS-1].sum + signed'(dquo[NS-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) dv[i] <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < NS; i++) dv[i] <= cv[i];
      vout <= dv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        dw[i]   <= cw[i];
        drem[i] <= s1[i].rem;
        dnum[i] <= {cnum[i][55:0], 8'b0};
        dquo[i] <= {cquo[i][55:0], s0[i].digit, s1[i].digit};
      end
      wout <= wout_next;
    end
  end

endmodule

// ===== rtl/core/sct_back.sv =====
// Back end: squares the folded angle, runs the term chain, rounds and saturates the result.
// Depends on sct_pkg, sct_mul and sct_term.
module sct_back #(
  parameter int NUM_TERMS        = 12,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  sct_pkg::fold_t     fin,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value
);

  localparam int SH = sct_pkg::FRAC - RESULT_FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (SH - 1);
  localparam logic [63:0] LIM  = 64'(1) << RESULT_FRAC_BITS;

  logic           en;
  sct_pkg::work_t w0, mw, sq_w;
  logic           mv;
  logic [63:0]    mprod;
  logic           tv [NUM_TERMS];
  sct_pkg::work_t tw [NUM_TERMS];

  logic        o1v, o1neg;
  logic [63:0] o1mag, rnd, sat;
  logic        neg_next;
  logic [63:0] mag_next;

  assign en  = ~(out_valid & out_stall);
  assign pop = ~empty & en;

  always_comb begin
    w0.kind = fin.kind;
    w0.neg  = fin.neg;
    w0.x2   = '0;
    w0.term = fin.kind ? sct_pkg::ONE_Q59 : 64'(fin.x);
    w0.sum  = signed'(w0.term);
  end

  sct_mul u_sq (
    .clk (clk), .rst (rst), .en (en), .vin (~empty), .win (w0),
    .a (64'(fin.x)), .b (64'(fin.x)),
    .vout (mv), .wout (mw), .prod (mprod)
  );

  always_comb begin
    sq_w    = mw;
    sq_w.x2 = mprod;
  end

  assign tv[0] = mv;
  assign tw[0] = sq_w;

  for (genvar i = 1; i < NUM_TERMS; i++) begin : g_term
    sct_term #(.TERM_IDX(i)) u_term (
      .clk (clk), .rst (rst), .en (en), .vin (tv[i-1]), .win (tw[i-1]),
      .vout (tv[i]), .wout (tw[i])
    );
  end

  always_comb begin
    neg_next = tw[NUM_TERMS-1].neg;
    mag_next = 64'(tw[NUM_TERMS-1].sum);
    if (tw[NUM_TERMS-1].sum < 0) begin
      neg_next = ~neg_next;
      mag_next = 64'(-tw[NUM_TERMS-1].sum);
    end
    rnd = (o1mag + HALF) >> SH;
    sat = (rnd > LIM) ? LIM : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      o1v       <= tv[NUM_TERMS-1];
      out_valid <= o1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1neg <= neg_next;
      o1mag <= mag_next;
      value <= o1neg ? -signed'(sat[31:0]) : signed'(sat[31:0]);
    end
  end

endmodule

// ===== rtl/core/sine_cosine_taylor.sv =====
// Top level of the sine/cosine unit: front end, queue and series back end.
// Depends on sct_pkg, sct_front, sct_queue and sct_back.
//
//   channel | ports                     | payload
//   input   | in_valid / in_stall       | kind (1b), angle (Q8.24 signed)
//   output  | out_valid / out_stall     | value (signed, RESULT_FRAC_BITS fraction)
//
// One angle per cycle sustained while in_stall is low. An angle passes through
// the front stages, the queue, the squaring multiplier, the NUM_TERMS-1 series
// terms and output registers. Reset clears only valid bits, queue pointers and cnt.
// Front and back stall independently; the back end holds while out_stall and
// out_valid are high, the front while its last stage cannot enter the queue.
module sine_cosine_taylor #(
  parameter int NUM_TERMS        = 12,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value
);

  logic           push, pop, full, empty;
  sct_pkg::fold_t fdata, qdata;

  sct_front u_front (
    .clk (clk), .rst (rst), .valid (in_valid), .stall (in_stall),
    .kind (kind), .angle (angle), .full (full), .push (push), .fout (fdata)
  );

  sct_queue u_queue (
    .clk (clk), .rst (rst), .push (push), .wdata (fdata), .pop (pop),
    .rdata (qdata), .full (full), .empty (empty)
  );

  sct_back #(
    .NUM_TERMS (NUM_TERMS), .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_back (
    .clk (clk), .rst (rst), .empty (empty), .fin (qdata), .pop (pop),
    .out_valid (out_valid), .out_stall (out_stall), .value (value)
  );

endmodule
